FILE: rtl/pfu_pkg.sv
// Package for the particle fountain update core.
// Holds state and pipeline types, fixed-point constants and arithmetic helpers.
// No dependencies.
package pfu_pkg;

	localparam int NP = 256;
	localparam int IDX_W = 8;

	localparam logic signed [31:0] K_INV_SQRT5 = 32'sd480191942;
	localparam logic signed [31:0] K_TWO_INV_SQRT5 = 32'sd960383884;
	localparam logic signed [31:0] K_ONE_Q30 = 32'sd1073741824;
	localparam logic signed [16:0] K_DAMP_Y = 17'sd22282;

	// Sqrt iterations, divide iterations, opacity divide iterations
	localparam int SQ_N = 32;
	localparam int DV_N = 31;
	localparam int OP_N = 16;
	localparam int LAST = SQ_N + DV_N + 2;

	typedef enum logic [2:0] {
		CFG_CENTER_X,
		CFG_CENTER_Y,
		CFG_CENTER_Z,
		CFG_EXTENT_X,
		CFG_EXTENT_Z,
		CFG_MAX_LIFE,
		CFG_SPEED,
		CFG_OPACITY
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] life;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [15:0]        op;
	} pstate_t;

	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic               resp;
		logic               zero;
		logic               sa;
		logic               sc;
		logic signed [31:0] life;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [15:0]        op_old;
		logic [15:0]        op_new;
		logic [31:0]        ma;
		logic [31:0]        mc;
	} ctx_t;

	typedef struct packed {
		logic [63:0] rad;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem_a;
		logic [32:0] rem_c;
		logic [30:0] qa;
		logic [30:0] qc;
		logic [31:0] len;
	} dv_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [15:0] lo;
		logic [15:0] q;
		logic        sat;
		logic        zm;
	} op_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic sq_t sq_step(input sq_t s);
		logic [35:0] t;
		logic [35:0] trial;
		sq_t r;
		t = {s.rem, s.rad[63:62]};
		trial = {2'b00, s.root, 2'b01};
		r.rad = {s.rad[61:0], 2'b00};
		if (t >= trial) begin
			r.rem = 34'(t - trial);
			r.root = {s.root[30:0], 1'b1};
		end else begin
			r.rem = t[33:0];
			r.root = {s.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// Returns {quotient bit, remainder}
	function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [31:0] len,
		input logic b);
		logic [33:0] t;
		t = {rem, b};
		if (t >= {2'b00, len})
			return {1'b1, 33'(t - {2'b00, len})};
		else
			return {1'b0, t[32:0]};
	endfunction

	function automatic op_t op_step(input op_t s, input logic [30:0] mx);
		logic [31:0] t;
		op_t r;
		t = {s.rem, s.lo[15]};
		r = s;
		r.lo = {s.lo[14:0], 1'b0};
		if (t >= {1'b0, mx}) begin
			r.rem = 31'(t - {1'b0, mx});
			r.q = {s.q[14:0], 1'b1};
		end else begin
			r.rem = t[30:0];
			r.q = {s.q[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: rtl/particle_fountain_update_core.sv
// Particle fountain update core: per-particle state memory with a deep update pipeline.
// Depends on pfu_pkg.
// One beat is accepted per cycle while busy is low; done is registered from the write-back beat.
// A later item for a particle in flight sees busy until the write-back edge.
// The pipeline holds a 32-step square root, two 31-step dividers and a 16-step opacity
// divider, one step per stage.
// Reset: config to defaults, all particles read as zero via per-particle valid bits;
// no clearing pass. Results cannot be stalled.
module particle_fountain_update_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [pfu_pkg::IDX_W-1:0] particle_index,
	input  logic [15:0]               time_step,
	input  logic [15:0]               rand_life,
	input  logic [15:0]               rand_pos_x,
	input  logic [15:0]               rand_pos_z,
	input  logic [15:0]               rand_dir_x,
	input  logic [15:0]               rand_dir_z,
	input  logic                      cfg_wr_en,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	output logic                      done,
	output logic [pfu_pkg::IDX_W-1:0] out_index,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic signed [31:0]        pos_z,
	output logic [15:0]               opacity,
	output logic                      respawned
);
	import pfu_pkg::*;

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        extent_x_q, extent_z_q, max_life_q, speed_q;
	logic [15:0]        init_op_q;

	pstate_t            mem [NP];
	logic [NP-1:0]      ok_q;
	logic [NP-1:0]      pend_q;
	logic               accept;

	// stage 1
	logic               v_s1, ok_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [15:0]        dt_s1, rl_s1, rpx_s1, rpz_s1, rdx_s1, rdz_s1;
	pstate_t            rd_s1, st;
	logic signed [32:0] life_d;
	logic signed [31:0] life1;
	logic signed [17:0] fx, fz;
	logic [16:0]        omd;

	// stage 2
	logic               v_s2, resp_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [15:0]        rdx_s2, rdz_s2;
	pstate_t            st_s2;
	logic signed [31:0] life_s2;
	logic signed [49:0] pxm_s2, pzm_s2, vxd_s2, vzd_s2;
	logic [46:0]        lifem_s2;
	logic signed [48:0] vxdt_s2, vydt_s2, vzdt_s2;
	logic signed [33:0] off_x, off_z;
	logic signed [32:0] ydt;

	// stage 3
	logic               v_s3, resp_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic signed [50:0] am_s3, cm_s3;
	logic signed [31:0] rpx_s3, rpy_s3, rpz_s3, npx_s3, npy_s3, npz_s3;
	logic signed [49:0] ydm_s3;
	logic signed [31:0] vy_s3, nvx_s3, nvz_s3, nlife_s3, life_s3;
	logic [46:0]        num_s3;
	logic [15:0]        opold_s3;
	logic signed [34:0] a3, c3, ma3, mc3;
	logic signed [31:0] nvy3;

	// stage 4
	logic               v_s4;
	ctx_t               ctx_s4;
	logic [63:0]        sqa_s4, sqc_s4;
	op_t                op_s4;

	// deep pipeline
	ctx_t               ctx_q [0:LAST];
	logic [LAST:0]      vld_q;
	sq_t                sq_q [0:SQ_N];
	op_t                opd_q [0:OP_N];
	dv_t                dv_q [1:DV_N];
	logic signed [63:0] kx_q, kz_q;
	logic signed [63:0] mvx_q, mvy_q, mvz_q;
	logic signed [31:0] ux, uz, dxk, dzk, dyk;
	ctx_t               fin;
	pstate_t            wr_st;

	assign accept = start && !busy;
	assign busy = pend_q[particle_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			extent_x_q <= 31'd65536;
			extent_z_q <= 31'd65536;
			max_life_q <= 31'd65536;
			speed_q <= 31'd65536;
			init_op_q <= 16'hffff;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_CENTER_Z: center_z_q <= cfg_data;
				CFG_EXTENT_X: extent_x_q <= cfg_data[30:0];
				CFG_EXTENT_Z: extent_z_q <= cfg_data[30:0];
				CFG_MAX_LIFE: max_life_q <= cfg_data[30:0];
				CFG_SPEED: speed_q <= cfg_data[30:0];
				CFG_OPACITY: init_op_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// state memory
	always_ff @(posedge clk) begin
		if (vld_q[LAST])
			mem[fin.idx] <= wr_st;
		rd_s1 <= mem[particle_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= '0;
			pend_q <= '0;
		end else begin
			if (vld_q[LAST]) begin
				ok_q[fin.idx] <= 1'b1;
				pend_q[fin.idx] <= 1'b0;
			end
			if (accept)
				pend_q[particle_index] <= 1'b1;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vld_q <= {vld_q[LAST-1:0], v_s4};
		end
	end

	// stage 1: lifetime, respawn test, first products
	always_ff @(posedge clk) begin
		idx_s1 <= particle_index;
		ok_s1 <= ok_q[particle_index];
		dt_s1 <= time_step;
		rl_s1 <= rand_life;
		rpx_s1 <= rand_pos_x;
		rpz_s1 <= rand_pos_z;
		rdx_s1 <= rand_dir_x;
		rdz_s1 <= rand_dir_z;
	end

	always_comb begin
		st = ok_s1 ? rd_s1 : '0;
		life_d = 33'(st.life) - 33'(dt_s1);
		life1 = sat32(64'(life_d));
		fx = $signed({1'b0, rpx_s1, 1'b0}) - 18'sd65536;
		fz = $signed({1'b0, rpz_s1, 1'b0}) - 18'sd65536;
		omd = 17'd65536 - {1'b0, dt_s1};
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		rdx_s2 <= rdx_s1;
		rdz_s2 <= rdz_s1;
		st_s2 <= st;
		life_s2 <= life1;
		resp_s2 <= life1[31] || (life1 == 32'sd0);
		pxm_s2 <= $signed({1'b0, extent_x_q}) * fx;
		pzm_s2 <= $signed({1'b0, extent_z_q}) * fz;
		lifem_s2 <= rl_s1 * max_life_q;
		vxdt_s2 <= st.vx * $signed({1'b0, dt_s1});
		vydt_s2 <= st.vy * $signed({1'b0, dt_s1});
		vzdt_s2 <= st.vz * $signed({1'b0, dt_s1});
		vxd_s2 <= st.vx * $signed({1'b0, omd});
		vzd_s2 <= st.vz * $signed({1'b0, omd});
	end

	// stage 2: spawn offsets, moves, damping
	always_comb begin
		off_x = $signed(pxm_s2[49:16]);
		off_z = $signed(pzm_s2[49:16]);
		ydt = $signed(vydt_s2[48:16]);
	end

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		resp_s3 <= resp_s2;
		am_s3 <= off_x * $signed({1'b0, rdx_s2});
		cm_s3 <= off_z * $signed({1'b0, rdz_s2});
		rpx_s3 <= sat32(64'(center_x_q + off_x));
		rpy_s3 <= center_y_q;
		rpz_s3 <= sat32(64'(center_z_q + off_z));
		npx_s3 <= sat32(64'(st_s2.px + $signed(vxdt_s2[48:16])));
		npy_s3 <= sat32(64'(st_s2.py + ydt));
		npz_s3 <= sat32(64'(st_s2.pz + $signed(vzdt_s2[48:16])));
		ydm_s3 <= ydt * K_DAMP_Y;
		vy_s3 <= st_s2.vy;
		nvx_s3 <= sat32(64'($signed(vxd_s2[49:16])));
		nvz_s3 <= sat32(64'($signed(vzd_s2[49:16])));
		nlife_s3 <= 32'(lifem_s2[46:16]);
		life_s3 <= life_s2;
		num_s3 <= life_s2[30:0] * init_op_q;
		opold_s3 <= st_s2.op;
	end

	// stage 3: direction magnitudes, path select, opacity divide setup
	always_comb begin
		a3 = $signed(am_s3[50:16]);
		c3 = $signed(cm_s3[50:16]);
		ma3 = a3[34] ? -a3 : a3;
		mc3 = c3[34] ? -c3 : c3;
		nvy3 = sat32(64'(vy_s3 - $signed(ydm_s3[49:16])));
	end

	always_ff @(posedge clk) begin
		ctx_s4.idx <= idx_s3;
		ctx_s4.resp <= resp_s3;
		ctx_s4.zero <= (a3 == 35'sd0) && (c3 == 35'sd0);
		ctx_s4.sa <= a3[34];
		ctx_s4.sc <= c3[34];
		ctx_s4.life <= resp_s3 ? nlife_s3 : life_s3;
		ctx_s4.px <= resp_s3 ? rpx_s3 : npx_s3;
		ctx_s4.py <= resp_s3 ? rpy_s3 : npy_s3;
		ctx_s4.pz <= resp_s3 ? rpz_s3 : npz_s3;
		ctx_s4.vx <= nvx_s3;
		ctx_s4.vy <= nvy3;
		ctx_s4.vz <= nvz_s3;
		ctx_s4.op_old <= opold_s3;
		ctx_s4.op_new <= opold_s3;
		ctx_s4.ma <= ma3[31:0];
		ctx_s4.mc <= mc3[31:0];
		sqa_s4 <= ma3[31:0] * ma3[31:0];
		sqc_s4 <= mc3[31:0] * mc3[31:0];
		op_s4.rem <= num_s3[46:16];
		op_s4.lo <= num_s3[15:0];
		op_s4.q <= '0;
		op_s4.sat <= num_s3[46:16] >= max_life_q;
		op_s4.zm <= max_life_q == 31'd0;
	end

	// stage 4: radicand
	always_ff @(posedge clk) begin
		ctx_q[0] <= ctx_s4;
		sq_q[0].rad <= sqa_s4 + sqc_s4;
		sq_q[0].rem <= '0;
		sq_q[0].root <= '0;
		opd_q[0] <= op_s4;
	end

	for (genvar s = 0; s < LAST; s++) begin : g_ctx
		if (s == OP_N) begin : g_merge
			ctx_t mrg;
			always_comb begin
				mrg = ctx_q[s];
				if (opd_q[OP_N].zm)
					mrg.op_new = init_op_q;
				else if (opd_q[OP_N].sat)
					mrg.op_new = 16'hffff;
				else
					mrg.op_new = opd_q[OP_N].q;
			end
			always_ff @(posedge clk) begin
				ctx_q[s+1] <= mrg;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				ctx_q[s+1] <= ctx_q[s];
			end
		end
	end

	for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
		always_ff @(posedge clk) begin
			sq_q[i+1] <= sq_step(sq_q[i]);
		end
	end

	for (genvar i = 0; i < OP_N; i++) begin : g_opdiv
		always_ff @(posedge clk) begin
			opd_q[i+1] <= op_step(opd_q[i], max_life_q);
		end
	end

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		if (j == 0) begin : g_first
			logic [33:0] ra, rc;
			assign ra = div_step({2'b00, ctx_q[SQ_N].ma[31:1]}, sq_q[SQ_N].root,
				ctx_q[SQ_N].ma[0]);
			assign rc = div_step({2'b00, ctx_q[SQ_N].mc[31:1]}, sq_q[SQ_N].root,
				ctx_q[SQ_N].mc[0]);
			always_ff @(posedge clk) begin
				dv_q[1].rem_a <= ra[32:0];
				dv_q[1].rem_c <= rc[32:0];
				dv_q[1].qa <= {30'd0, ra[33]};
				dv_q[1].qc <= {30'd0, rc[33]};
				dv_q[1].len <= sq_q[SQ_N].root;
			end
		end else begin : g_next
			logic [33:0] ra, rc;
			assign ra = div_step(dv_q[j].rem_a, dv_q[j].len, 1'b0);
			assign rc = div_step(dv_q[j].rem_c, dv_q[j].len, 1'b0);
			always_ff @(posedge clk) begin
				dv_q[j+1].rem_a <= ra[32:0];
				dv_q[j+1].rem_c <= rc[32:0];
				dv_q[j+1].qa <= {dv_q[j].qa[29:0], ra[33]};
				dv_q[j+1].qc <= {dv_q[j].qc[29:0], rc[33]};
				dv_q[j+1].len <= dv_q[j].len;
			end
		end
	end

	// unit vector, second normalize, launch speed
	always_comb begin
		ux = ctx_q[LAST-2].sa ? -(32'(dv_q[DV_N].qa)) : 32'(dv_q[DV_N].qa);
		uz = ctx_q[LAST-2].sc ? -(32'(dv_q[DV_N].qc)) : 32'(dv_q[DV_N].qc);
		dxk = ctx_q[LAST-1].zero ? 32'sd0 : $signed(kx_q[61:30]);
		dzk = ctx_q[LAST-1].zero ? 32'sd0 : $signed(kz_q[61:30]);
		dyk = ctx_q[LAST-1].zero ? K_ONE_Q30 : K_TWO_INV_SQRT5;
	end

	always_ff @(posedge clk) begin
		kx_q <= ux * K_INV_SQRT5;
		kz_q <= uz * K_INV_SQRT5;
		mvx_q <= dxk * $signed({1'b0, speed_q});
		mvy_q <= dyk * $signed({1'b0, speed_q});
		mvz_q <= dzk * $signed({1'b0, speed_q});
	end

	// write-back
	always_comb begin
		fin = ctx_q[LAST];
		wr_st.life = fin.life;
		wr_st.px = fin.px;
		wr_st.py = fin.py;
		wr_st.pz = fin.pz;
		wr_st.vx = fin.resp ? sat32(64'($signed(mvx_q[63:30]))) : fin.vx;
		wr_st.vy = fin.resp ? sat32(64'($signed(mvy_q[63:30]))) : fin.vy;
		wr_st.vz = fin.resp ? sat32(64'($signed(mvz_q[63:30]))) : fin.vz;
		wr_st.op = fin.resp ? fin.op_old : fin.op_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_q[LAST];
	end

	always_ff @(posedge clk) begin
		out_index <= fin.idx;
		pos_x <= wr_st.px;
		pos_y <= wr_st.py;
		pos_z <= wr_st.pz;
		opacity <= wr_st.op;
		respawned <= fin.resp;
	end

	a_wb_pending: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAST] |-> pend_q[fin.idx])
		else $error("write-back for a particle not marked in flight");

	a_acc_marks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q[$past(particle_index)])
		else $error("accepted particle not marked in flight");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAST] |-> !(accept && (particle_index == fin.idx)))
		else $error("accept collides with write-back of same particle");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[LAST]))
		else $error("done without a finishing beat");

endmodule

FILE: bench/tb_particle_fountain_update_core.sv
// Testbench for particle_fountain_update_core: random and directed particle updates
// checked beat by beat against a scoreboard that predicts every particle's state.
// Depends on pfu_pkg and particle_fountain_update_core.
`timescale 1ns / 100ps

module tb_particle_fountain_update_core;
	import pfu_pkg::*;

	typedef struct {
		logic [7:0]  idx;
		int          px;
		int          py;
		int          pz;
		logic [15:0] op;
		logic        rsp;
	} particle_beat_t;

	class fountain_scoreboard;
		longint cx, cy, cz, ex, ez, mlife, speed, iop;
		int life[NP];
		int pos[3*NP];
		int vel[3*NP];
		logic [15:0] op[NP];
		particle_beat_t pending[$];
		int errors;

		function new();
			cx = 0; cy = 0; cz = 0;
			ex = 65536; ez = 65536; mlife = 65536; speed = 65536; iop = 65535;
			foreach (life[i]) begin
				life[i] = 0;
				op[i] = 0;
			end
			foreach (pos[i]) begin
				pos[i] = 0;
				vel[i] = 0;
			end
			errors = 0;
		endfunction

		static function int clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return int'(v);
		endfunction

		static function longint unsigned root64(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		static function longint unit_dir(longint a, longint unsigned len);
			longint unsigned mag;
			longint q;
			mag = (a < 0) ? -a : a;
			q = longint'((mag << 30) / len);
			return (a < 0) ? -q : q;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [31:0] d);
			case (idx)
				CFG_CENTER_X: cx = longint'(signed'(d));
				CFG_CENTER_Y: cy = longint'(signed'(d));
				CFG_CENTER_Z: cz = longint'(signed'(d));
				CFG_EXTENT_X: ex = d[30:0];
				CFG_EXTENT_Z: ez = d[30:0];
				CFG_MAX_LIFE: mlife = d[30:0];
				CFG_SPEED: speed = d[30:0];
				CFG_OPACITY: iop = d[15:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic [7:0] idx, logic [15:0] dt_in, logic [15:0] r_life,
			logic [15:0] r_px, logic [15:0] r_pz, logic [15:0] r_dx, logic [15:0] r_dz);
			longint dt, lf, offx, offz, a, c, dx, dy, dz, vx, vy, vz, ydt, o;
			longint unsigned ma, mc, len;
			int s;
			bit rsp;
			particle_beat_t e;
			s = idx;
			dt = dt_in;
			lf = clamp32(longint'(life[s]) - dt);
			rsp = (lf <= 0);
			if (rsp) begin
				offx = (ex * (2 * longint'(r_px) - 65536)) >>> 16;
				offz = (ez * (2 * longint'(r_pz) - 65536)) >>> 16;
				a = (offx * longint'(r_dx)) >>> 16;
				c = (offz * longint'(r_dz)) >>> 16;
				dx = 0;
				dy = 64'sd1 << 30;
				dz = 0;
				lf = (longint'(r_life) * mlife) >>> 16;
				pos[3*s] = clamp32(cx + offx);
				pos[3*s+1] = clamp32(cy);
				pos[3*s+2] = clamp32(cz + offz);
				if (a != 0 || c != 0) begin
					ma = (a < 0) ? -a : a;
					mc = (c < 0) ? -c : c;
					len = root64(ma * ma + mc * mc);
					dx = (unit_dir(a, len) * longint'(K_INV_SQRT5)) >>> 30;
					dz = (unit_dir(c, len) * longint'(K_INV_SQRT5)) >>> 30;
					dy = K_TWO_INV_SQRT5;
				end
				vel[3*s] = clamp32((dx * speed) >>> 30);
				vel[3*s+1] = clamp32((dy * speed) >>> 30);
				vel[3*s+2] = clamp32((dz * speed) >>> 30);
			end else begin
				vx = vel[3*s];
				vy = vel[3*s+1];
				vz = vel[3*s+2];
				ydt = (vy * dt) >>> 16;
				o = (mlife == 0) ? iop : (lf * iop) / mlife;
				if (o > 65535)
					o = 65535;
				op[s] = o[15:0];
				pos[3*s] = clamp32(longint'(pos[3*s]) + ((vx * dt) >>> 16));
				pos[3*s+1] = clamp32(longint'(pos[3*s+1]) + ydt);
				pos[3*s+2] = clamp32(longint'(pos[3*s+2]) + ((vz * dt) >>> 16));
				vel[3*s] = clamp32((vx * (65536 - dt)) >>> 16);
				vel[3*s+1] = clamp32(vy - ((ydt * longint'(K_DAMP_Y)) >>> 16));
				vel[3*s+2] = clamp32((vz * (65536 - dt)) >>> 16);
			end
			life[s] = int'(lf);
			e.idx = idx;
			e.px = pos[3*s];
			e.py = pos[3*s+1];
			e.pz = pos[3*s+2];
			e.op = op[s];
			e.rsp = rsp;
			pending.insert(pending.size(), e);
		endfunction

		function void check_beat(particle_beat_t got);
			particle_beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected beat for particle %0d", got.idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.idx !== e.idx) begin
				$error("out_index: expected %0d, got %0d", e.idx, got.idx);
				errors++;
			end
			if (got.px !== e.px) begin
				$error("pos_x: expected %0d, got %0d", e.px, got.px);
				errors++;
			end
			if (got.py !== e.py) begin
				$error("pos_y: expected %0d, got %0d", e.py, got.py);
				errors++;
			end
			if (got.pz !== e.pz) begin
				$error("pos_z: expected %0d, got %0d", e.pz, got.pz);
				errors++;
			end
			if (got.op !== e.op) begin
				$error("opacity: expected %0d, got %0d", e.op, got.op);
				errors++;
			end
			if (got.rsp !== e.rsp) begin
				$error("respawned: expected %0d, got %0d", e.rsp, got.rsp);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_wr_en, done, respawned;
	logic [IDX_W-1:0] particle_index, out_index;
	logic [15:0] time_step, rand_life, rand_pos_x, rand_pos_z, rand_dir_x, rand_dir_z;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [15:0] opacity;

	fountain_scoreboard sb;
	longint cycles;

	particle_fountain_update_core dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		particle_beat_t b;
		if (done) begin
			b.idx = out_index;
			b.px = pos_x;
			b.py = pos_y;
			b.pz = pos_z;
			b.op = opacity;
			b.rsp = respawned;
			sb.check_beat(b);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic idle_gap();
		int g, r;
		r = $urandom_range(0, 99);
		g = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_update(logic [7:0] idx, logic [15:0] dt, logic [15:0] rl,
		logic [15:0] px, logic [15:0] pz, logic [15:0] dx, logic [15:0] dz);
		start <= 1'b1;
		particle_index <= idx;
		time_step <= dt;
		rand_life <= rl;
		rand_pos_x <= px;
		rand_pos_z <= pz;
		rand_dir_x <= dx;
		rand_dir_z <= dz;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(idx, dt, rl, px, pz, dx, dz);
		idle_gap();
	endtask

	task automatic send_random();
		logic [7:0] idx;
		logic [15:0] dt, dx, dz;
		int r;
		idx = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 255));
		r = $urandom_range(0, 9);
		dt = 16'((r < 6) ? $urandom_range(0, 2048) : (r < 9) ? $urandom :
			(r[0] ? 32'h0000ffff : 32'h00000000));
		dx = 16'($urandom);
		dz = 16'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			dx = 0;
			dz = 0;
		end
		send_update(idx, dt, 16'($urandom), 16'($urandom), 16'($urandom), dx, dz);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] v[8]);
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= v[i];
			@(posedge clk);
			sb.write_reg(cfg_idx_t'(i), v[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [31:0] v[8];
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		particle_index = '0;
		time_step = '0;
		rand_life = '0;
		rand_pos_x = '0;
		rand_pos_z = '0;
		rand_dir_x = '0;
		rand_dir_z = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero direction, repeated moves, dt extremes
		send_update(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_update(8'd255, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_update(8'd1, 16'd0, 16'hffff, 16'd32768, 16'd32768, 16'hffff, 16'hffff);
		send_update(8'd2, 16'd0, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'd0);
		send_update(8'd3, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd1);
		for (int i = 0; i < 4; i++) begin
			send_update(8'd0, 16'd1000, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5);
			send_update(8'd3, 16'd8000, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5);
		end
		send_update(8'd255, 16'hffff, 16'h1234, 16'h8000, 16'h0001, 16'h7fff, 16'h8000);
		send_update(8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
					32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0000ffff};
				1: v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0,
					32'h1, 32'h0, 32'h0};
				2: v = '{$urandom, $urandom, $urandom, $urandom_range(1, 1 << 20),
					$urandom_range(1, 1 << 20), (ph == 2) ? 32'h0 : $urandom_range(1, 1 << 18),
					$urandom_range(1, 1 << 22), $urandom_range(0, 65535)};
				default: v = '{$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
					$urandom_range(0, 1 << 20), $urandom_range(1, 1 << 17),
					$urandom_range(1, 1 << 17), $urandom_range(1, 1 << 17),
					$urandom_range(1, 1 << 18), $urandom_range(0, 65535)};
			endcase
			load_regs(v);
			for (int i = 0; i < 235; i++)
				send_random();
			// shrink lifetime range so stored lifetimes exceed it
			if (ph % 4 == 3) begin
				v[5] = $urandom_range(1, 64);
				load_regs(v);
				for (int i = 0; i < 20; i++)
					send_random();
			end
		end

		drain();
		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

FILE: files.f
rtl/pfu_pkg.sv
rtl/particle_fountain_update_core.sv
bench/tb_particle_fountain_update_core.sv
